// ----- rtl/lutf8_pkg.sv -----
// ----------------------------------------------------------------------------
// lutf8_pkg
// shared widths, types and byte decode functions of the utf-8 stream decoder
// ----------------------------------------------------------------------------
package lutf8_pkg;

    localparam int BYTE_W     = 8;
    localparam int CP_W       = 21;
    localparam int LEN_W      = 3;
    localparam int HOLD_DEPTH = 3;
    localparam int HCNT_W     = 2;
    localparam int IDX_W      = 2;
    localparam int Q_DEPTH    = 2;
    localparam int QPTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CP_W-1:0]   t_cp;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [HCNT_W-1:0] t_hcnt;
    typedef logic [IDX_W-1:0]  t_idx;

    localparam t_len LEN_NONE = 3'd0;
    localparam t_len LEN_1    = 3'd1;
    localparam t_len LEN_2    = 3'd2;
    localparam t_len LEN_3    = 3'd3;
    localparam t_len LEN_4    = 3'd4;

    localparam t_hcnt HCNT_IDLE = 2'd0;
    localparam t_hcnt HCNT_ONE  = 2'd1;
    localparam t_hcnt HCNT_TWO  = 2'd2;
    localparam t_hcnt HCNT_FULL = 2'd3;

    localparam t_idx IDX_0 = 2'd0;
    localparam t_idx IDX_1 = 2'd1;
    localparam t_idx IDX_2 = 2'd2;

    // one queue entry: up to three code points, last_idx marks the final one
    typedef struct packed {
        t_idx last_idx;
        t_cp  cp2;
        t_cp  cp1;
        t_cp  cp0;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_q_wr;

    typedef struct packed {
        logic not_empty;
        t_cmd head;
    } t_q_rd;

    function automatic t_len f_lead_len(input t_byte b);
        t_len len;
        case (b) inside
            8'b0???????: len = LEN_1;
            8'b110?????: len = LEN_2;
            8'b1110????: len = LEN_3;
            8'b11110???: len = LEN_4;
            default:     len = LEN_NONE;
        endcase
        return len;
    endfunction

    function automatic t_cp f_raw(input t_byte b);
        return CP_W'(b);
    endfunction

    function automatic t_cp f_dec2(input t_byte b0, input t_byte b1);
        return CP_W'({b0[4:0], b1[5:0]});
    endfunction

    function automatic t_cp f_dec3(input t_byte b0, input t_byte b1, input t_byte b2);
        return CP_W'({b0[3:0], b1[5:0], b2[5:0]});
    endfunction

    function automatic t_cp f_dec4(input t_byte b0, input t_byte b1, input t_byte b2,
                                   input t_byte b3);
        return CP_W'({b0[2:0], b1[5:0], b2[5:0], b3[5:0]});
    endfunction

endpackage

// ----- rtl/lutf8_if.sv -----
// ----------------------------------------------------------------------------
// lutf8_in_if / lutf8_out_if
// valid/ready channels for the byte items in and the code point items out
// ----------------------------------------------------------------------------
interface lutf8_in_if import lutf8_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface lutf8_out_if import lutf8_pkg::*; ();
    logic valid;
    logic ready;
    t_cp  code_point;
    logic last_of_run;

    modport source (output valid, output code_point, output last_of_run, input ready);
    modport sink   (input valid, input code_point, input last_of_run, output ready);
endinterface

// ----- rtl/lenient_utf8_stream_decoder_top.sv -----
// path: a result is registered in the queue, then in the output register, after its byte item is accepted
// throughput: one byte item per cycle while each item gives at most one result and the output is ready
// an end of stream that flushes two or three results holds the back stage until all are sent,
// so byte items that give results right after it can stall
// reset: synchronous active low, clears the pending count, queue and output valid
// ----------------------------------------------------------------------------
// lenient_utf8_stream_decoder_top
// lenient utf-8 byte stream to code point decoder
// ----------------------------------------------------------------------------
module lenient_utf8_stream_decoder_top import lutf8_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lutf8_in_if.sink    i_in,
    lutf8_out_if.source o_out
);

    t_q_wr w_q_wr;
    t_q_rd w_q_rd;
    logic  w_q_full;
    logic  w_pop;

    lutf8_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_q_full),
        .o_q_wr   (w_q_wr)
    );

    lutf8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_wr  (w_q_wr),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_q_rd  (w_q_rd)
    );

    lutf8_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_rd  (w_q_rd),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

// ----- rtl/lutf8_front.sv -----
// ----------------------------------------------------------------------------
// lutf8_front
// accepts byte items, tracks the pending sequence and builds result commands
// ----------------------------------------------------------------------------
module lutf8_front import lutf8_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lutf8_in_if.sink        i_in,
    input  logic            i_q_full,
    output t_q_wr           o_q_wr
);

    t_byte r_held [HOLD_DEPTH];
    t_hcnt r_held_cnt;
    t_hcnt n_held_cnt;
    t_len  r_exp_len;
    t_len  n_exp_len;

    logic  w_accept;
    t_len  w_lead_len;
    logic  w_hold_we;
    t_hcnt w_hold_idx;
    t_q_wr w_q_wr;

    assign i_in.ready = !i_q_full;
    assign w_accept   = i_in.valid && !i_q_full;
    assign w_lead_len = f_lead_len(i_in.data_byte);
    assign o_q_wr     = w_q_wr;

    always_comb begin
        n_held_cnt          = r_held_cnt;
        n_exp_len           = r_exp_len;
        w_hold_we           = 1'b0;
        w_hold_idx          = r_held_cnt;
        w_q_wr.push         = 1'b0;
        w_q_wr.cmd.last_idx = IDX_0;
        w_q_wr.cmd.cp0      = f_raw(i_in.data_byte);
        w_q_wr.cmd.cp1      = f_raw(r_held[1]);
        w_q_wr.cmd.cp2      = f_raw(r_held[2]);
        if (w_accept) begin
            if (i_in.end_of_stream) begin
                // flush: lead alone, rest decoded again
                w_q_wr.cmd.cp0 = f_raw(r_held[0]);
                case (r_held_cnt)
                    HCNT_IDLE: begin
                        w_q_wr.push = 1'b0;
                    end
                    HCNT_ONE: begin
                        w_q_wr.push = 1'b1;
                    end
                    HCNT_TWO: begin
                        w_q_wr.push         = 1'b1;
                        w_q_wr.cmd.last_idx = IDX_1;
                    end
                    default: begin
                        w_q_wr.push = 1'b1;
                        if (f_lead_len(r_held[1]) == LEN_2) begin
                            w_q_wr.cmd.cp1      = f_dec2(r_held[1], r_held[2]);
                            w_q_wr.cmd.last_idx = IDX_1;
                        end else begin
                            w_q_wr.cmd.last_idx = IDX_2;
                        end
                    end
                endcase
                n_held_cnt = HCNT_IDLE;
                n_exp_len  = LEN_NONE;
            end else if (r_held_cnt == HCNT_IDLE) begin
                if (w_lead_len == LEN_NONE || w_lead_len == LEN_1) begin
                    w_q_wr.push = 1'b1;
                end else begin
                    w_hold_we  = 1'b1;
                    n_held_cnt = HCNT_ONE;
                    n_exp_len  = w_lead_len;
                end
            end else if (LEN_W'(r_held_cnt) + LEN_W'(1) == r_exp_len) begin
                w_q_wr.push = 1'b1;
                case (r_exp_len)
                    LEN_2:   w_q_wr.cmd.cp0 = f_dec2(r_held[0], i_in.data_byte);
                    LEN_3:   w_q_wr.cmd.cp0 = f_dec3(r_held[0], r_held[1], i_in.data_byte);
                    default: w_q_wr.cmd.cp0 = f_dec4(r_held[0], r_held[1], r_held[2],
                                                     i_in.data_byte);
                endcase
                n_held_cnt = HCNT_IDLE;
                n_exp_len  = LEN_NONE;
            end else begin
                w_hold_we  = 1'b1;
                n_held_cnt = r_held_cnt + HCNT_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= HCNT_IDLE;
            r_exp_len  <= LEN_NONE;
        end else begin
            r_held_cnt <= n_held_cnt;
            r_exp_len  <= n_exp_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hold_we) begin
            r_held[w_hold_idx] <= i_in.data_byte;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_cnt != HCNT_IDLE) |-> (LEN_W'(r_held_cnt) < r_exp_len))
        else $error("held count not below expected length");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.end_of_stream) |=> (r_held_cnt == HCNT_IDLE))
        else $error("decoder not idle after end of stream");

endmodule

// ----- rtl/lutf8_queue.sv -----
// ----------------------------------------------------------------------------
// lutf8_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
module lutf8_queue import lutf8_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_q_wr i_q_wr,
    input  logic  i_pop,
    output logic  o_full,
    output t_q_rd o_q_rd
);

    t_cmd              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_full           = (r_cnt == QCNT_W'(Q_DEPTH));
    assign o_q_rd.not_empty = (r_cnt != '0);
    assign o_q_rd.head      = r_mem[r_rd_ptr];
    assign w_push           = i_q_wr.push && !o_full;
    assign w_pop            = i_pop && o_q_rd.not_empty;

    function automatic logic [QPTR_W-1:0] f_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(Q_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_q_wr.cmd;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_wr.push |-> !o_full)
        else $error("command pushed into full queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(Q_DEPTH))
        else $error("queue count out of range");

endmodule

// ----- rtl/lutf8_back.sv -----
// ----------------------------------------------------------------------------
// lutf8_back
// expands queued commands into code point items through an output register
// ----------------------------------------------------------------------------
module lutf8_back import lutf8_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_rd      i_q_rd,
    output logic       o_pop,
    lutf8_out_if.source o_out
);

    logic r_valid;
    t_cp  r_cp;
    logic r_last;
    t_idx r_idx;
    t_cp  w_cp;
    logic w_is_last;
    logic w_load;

    assign w_load          = i_q_rd.not_empty && (!r_valid || o_out.ready);
    assign w_is_last       = (r_idx == i_q_rd.head.last_idx);
    assign o_pop           = w_load && w_is_last;
    assign o_out.valid     = r_valid;
    assign o_out.code_point = r_cp;
    assign o_out.last_of_run = r_last;

    always_comb begin
        case (r_idx)
            IDX_0:   w_cp = i_q_rd.head.cp0;
            IDX_1:   w_cp = i_q_rd.head.cp1;
            default: w_cp = i_q_rd.head.cp2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= IDX_0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_is_last ? IDX_0 : r_idx + IDX_1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cp   <= w_cp;
            r_last <= w_is_last;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_rd.not_empty |-> (r_idx <= i_q_rd.head.last_idx))
        else $error("result index past end of command");

endmodule
